[src/mlbt_pkg.sv]
package mlbt_pkg;

    localparam int NUM_LAMPS = 8;
    localparam int IDX_W     = (NUM_LAMPS > 1) ? $clog2(NUM_LAMPS) : 1;
    localparam int TIME_W    = 16;
    localparam int CNT_W     = 17;
    localparam int SEL_W     = 3;

    localparam logic [TIME_W-1:0] TIME_HOLD  = 16'hFFFF;
    localparam logic [TIME_W-1:0] TIME_LIMIT = 16'd60000;
    localparam logic [TIME_W-1:0] TIME_OFF   = 16'd0;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_SET  = 1'b1;

    typedef struct packed {
        logic [TIME_W-1:0] on_dur;
        logic [TIME_W-1:0] off_dur;
        logic [CNT_W-1:0]  on_cnt;
        logic [CNT_W-1:0]  off_cnt;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SET  = 3'b010,
        S_TICK = 3'b100
    } t_state;

    function automatic logic [TIME_W-1:0] f_clamp(input logic [TIME_W-1:0] v);
        logic [TIME_W-1:0] res;
        res = v;
        if (v > TIME_LIMIT && v != TIME_HOLD) begin
            res = TIME_LIMIT;
        end
        return res;
    endfunction

    function automatic logic f_timed(input logic [TIME_W-1:0] v);
        return (v != TIME_OFF) && (v != TIME_HOLD);
    endfunction

endpackage

[src/multi_lamp_blink_timer_top.sv]
// Lamp blink timer for NUM_LAMPS lamps. A set word (opcode 1) stores the on and off
// times of one lamp; a tick word (opcode 0) with nonzero elapsed time walks all
// lamps, one per cycle, as the per-lamp state sits in a table with a registered
// read and is read, updated and written back lamp by lamp. Set words for a lamp
// past the table and ticks with zero elapsed time finish at once. busy is high
// while a word is in work; start is taken only while busy is low. Each tick
// with nonzero elapsed time gives one result per lamp in index order on
// o_lamp_index/o_lamp_on, marked by o_valid for one cycle, with o_last on the
// final lamp. The receiver cannot stall: results must be taken in the cycle
// o_valid is high.
module multi_lamp_blink_timer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_opcode,
    input  logic [2:0]  i_lamp_select,
    input  logic [15:0] i_on_time,
    input  logic [15:0] i_off_time,
    input  logic [15:0] i_elapsed,
    output logic        o_valid,
    output logic [2:0]  o_lamp_index,
    output logic        o_lamp_on,
    output logic        o_last
);
    import mlbt_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_LAMPS - 1);

    t_state r_state, n_state;

    t_entry r_mem [NUM_LAMPS];
    logic [NUM_LAMPS-1:0] r_vld;

    t_entry            r_rdata;
    logic              r_rd_vld;
    logic [IDX_W-1:0]  rd_addr;

    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [TIME_W-1:0] r_on_time, r_off_time, r_elapsed;

    logic              wr_en;
    t_entry            wr_data;
    t_entry            cur;
    t_entry            tick_e;
    logic              tick_on;

    logic              accept;
    logic              sel_ok;

    logic              r_valid;
    logic [2:0]        r_lamp_index;
    logic              r_lamp_on;
    logic              r_last;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;
    assign sel_ok = (32'(i_lamp_select) < NUM_LAMPS);
    assign cur    = r_rd_vld ? r_rdata : '0;

    // per-lamp update for a tick
    always_comb begin
        logic [CNT_W-1:0] dt;
        logic [CNT_W-1:0] on_p;
        logic [CNT_W-1:0] off_p;
        dt      = CNT_W'(r_elapsed);
        on_p    = cur.on_cnt + dt;
        off_p   = cur.off_cnt + dt;
        tick_e  = cur;
        tick_on = 1'b1;
        if (cur.on_dur == TIME_OFF) begin
            tick_on = 1'b0;
        end else if (f_timed(cur.on_dur) && f_timed(cur.off_dur)) begin
            if (cur.on_cnt < CNT_W'(cur.on_dur)) begin
                tick_e.on_cnt = on_p;
                tick_on       = 1'b1;
            end else if (cur.off_cnt < CNT_W'(cur.off_dur)) begin
                tick_e.off_cnt = off_p;
                tick_on        = 1'b0;
            end else begin
                tick_e.on_cnt  = dt;
                tick_e.off_cnt = '0;
                tick_on        = 1'b0;
            end
        end else if (f_timed(cur.on_dur) && cur.off_dur == TIME_HOLD) begin
            if (cur.on_cnt < CNT_W'(cur.on_dur)) begin
                tick_e.on_cnt = on_p;
                tick_on       = 1'b1;
            end else begin
                tick_on = 1'b0;
            end
        end else if (cur.on_dur == TIME_HOLD && f_timed(cur.off_dur)) begin
            if (cur.off_cnt < CNT_W'(cur.off_dur)) begin
                tick_e.off_cnt = off_p;
                tick_on        = 1'b0;
            end else begin
                tick_on = 1'b1;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        rd_addr = r_idx;
        wr_en   = 1'b0;
        wr_data = tick_e;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_opcode == OP_SET) begin
                        rd_addr = IDX_W'(i_lamp_select);
                        n_idx   = IDX_W'(i_lamp_select);
                        if (sel_ok) begin
                            n_state = S_SET;
                        end
                    end else begin
                        rd_addr = '0;
                        n_idx   = '0;
                        if (i_elapsed != '0) begin
                            n_state = S_TICK;
                        end
                    end
                end
            end
            S_SET: begin
                wr_en           = 1'b1;
                wr_data         = cur;
                wr_data.on_dur  = r_on_time;
                wr_data.off_dur = r_off_time;
                if (f_timed(r_on_time) && r_off_time == TIME_HOLD) begin
                    wr_data.on_cnt = '0;
                end
                if (r_on_time != TIME_HOLD && f_timed(r_off_time)) begin
                    wr_data.off_cnt = '0;
                end
                n_state = S_IDLE;
            end
            S_TICK: begin
                wr_en   = 1'b1;
                wr_data = tick_e;
                if (r_idx == LAST_IDX) begin
                    n_state = S_IDLE;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    rd_addr = r_idx + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_vld   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (wr_en) begin
                r_vld[r_idx] <= 1'b1;
            end
            r_valid <= (r_state == S_TICK);
        end
    end

    // table storage and registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_idx] <= wr_data;
        end
        r_rdata  <= r_mem[rd_addr];
        r_rd_vld <= r_vld[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_lamp_index <= 3'(r_idx);
        r_lamp_on    <= tick_on;
        r_last       <= (r_idx == LAST_IDX);
        if (accept) begin
            r_on_time  <= f_clamp(i_on_time);
            r_off_time <= f_clamp(i_off_time);
            r_elapsed  <= i_elapsed;
        end
    end

    assign o_valid      = r_valid;
    assign o_lamp_index = r_lamp_index;
    assign o_lamp_on    = r_lamp_on;
    assign o_last       = r_last;

endmodule

[tb/sv/tb_multi_lamp_blink_timer_top.sv]
`timescale 1ns / 100ps

module tb_multi_lamp_blink_timer_top;

    import mlbt_pkg::*;

    localparam int RAND_ITEMS   = 150;
    localparam int DRAIN_CYCLES = 3 * NUM_LAMPS + 10;
    localparam int DIR_N        = 24;

    typedef struct packed {
        logic                 op;
        logic [2:0]           sel;
        logic [15:0]          on_t;
        logic [15:0]          off_t;
        logic [15:0]          el;
        logic                 typed;
        logic [NUM_LAMPS-1:0] pat;
    } t_stim_row;

    typedef struct packed {
        logic [2:0] idx;
        logic       lamp_on;
        logic       last;
    } t_drive_word;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_opcode;
    logic [2:0]  i_lamp_select;
    logic [15:0] i_on_time;
    logic [15:0] i_off_time;
    logic [15:0] i_elapsed;
    logic        o_valid;
    logic [2:0]  o_lamp_index;
    logic        o_lamp_on;
    logic        o_last;

    logic [15:0] lamp_on_dur  [NUM_LAMPS];
    logic [15:0] lamp_off_dur [NUM_LAMPS];
    logic [16:0] lamp_on_cnt  [NUM_LAMPS];
    logic [16:0] lamp_off_cnt [NUM_LAMPS];

    t_drive_word drive_q [$];

    int err_cnt;
    int n_sets;
    int n_ticks;
    int n_results;

    // extremes, every mode, clamping, zero elapsed and the periodic restart
    t_stim_row dir_tab [DIR_N] = '{
        '{OP_TICK, 3'd0, 16'd0,     16'd0,     16'd1,     1'b1, 8'h00},
        '{OP_TICK, 3'd0, 16'd0,     16'd0,     16'd0,     1'b0, 8'h00},
        '{OP_SET,  3'd0, 16'hFFFF,  16'hFFFF,  16'd0,     1'b0, 8'h00},
        '{OP_SET,  3'd1, 16'd0,     16'd500,   16'd0,     1'b0, 8'h00},
        '{OP_SET,  3'd2, 16'hFFFF,  16'd0,     16'd0,     1'b0, 8'h00},
        '{OP_SET,  3'd3, 16'd100,   16'hFFFF,  16'd0,     1'b0, 8'h00},
        '{OP_SET,  3'd4, 16'hFFFF,  16'd200,   16'd0,     1'b0, 8'h00},
        '{OP_SET,  3'd5, 16'd3,     16'd2,     16'd0,     1'b0, 8'h00},
        '{OP_SET,  3'd6, 16'd65534, 16'd60001, 16'd0,     1'b0, 8'h00},
        '{OP_SET,  3'd7, 16'd50,    16'd0,     16'd0,     1'b0, 8'h00},
        '{OP_TICK, 3'd0, 16'd0,     16'd0,     16'd1,     1'b1, 8'hED},
        '{OP_TICK, 3'd0, 16'd0,     16'd0,     16'hFFFF,  1'b0, 8'h00},
        '{OP_TICK, 3'd0, 16'd0,     16'd0,     16'd1,     1'b0, 8'h00},
        '{OP_TICK, 3'd0, 16'd0,     16'd0,     16'd1,     1'b0, 8'h00},
        '{OP_TICK, 3'd0, 16'd0,     16'd0,     16'd1,     1'b0, 8'h00},
        '{OP_TICK, 3'd0, 16'd0,     16'd0,     16'd1,     1'b0, 8'h00},
        '{OP_SET,  3'd5, 16'd60000, 16'd60000, 16'd0,     1'b0, 8'h00},
        '{OP_SET,  3'd3, 16'd60001, 16'hFFFF,  16'd0,     1'b0, 8'h00},
        '{OP_SET,  3'd1, 16'd1,     16'd1,     16'd0,     1'b0, 8'h00},
        '{OP_TICK, 3'd0, 16'd0,     16'd0,     16'hFFFF,  1'b0, 8'h00},
        '{OP_TICK, 3'd0, 16'd0,     16'd0,     16'd32768, 1'b0, 8'h00},
        '{OP_SET,  3'd0, 16'd0,     16'd0,     16'd0,     1'b0, 8'h00},
        '{OP_SET,  3'd4, 16'hFFFF,  16'hFFFF,  16'd0,     1'b0, 8'h00},
        '{OP_TICK, 3'd0, 16'd0,     16'd0,     16'd21845, 1'b0, 8'h00}
    };

    multi_lamp_blink_timer_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_opcode      (i_opcode),
        .i_lamp_select (i_lamp_select),
        .i_on_time     (i_on_time),
        .i_off_time    (i_off_time),
        .i_elapsed     (i_elapsed),
        .o_valid       (o_valid),
        .o_lamp_index  (o_lamp_index),
        .o_lamp_on     (o_lamp_on),
        .o_last        (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #200000;
        $display("timeout with %0d drive words outstanding", drive_q.size());
        $display("tb_multi_lamp_blink_timer_top failed");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        err_cnt++;
    endtask

    function automatic logic is_timed_dur(input logic [15:0] v);
        return (v != 16'd0) && (v != TIME_HOLD);
    endfunction

    function automatic logic [15:0] limit_dur(input logic [15:0] v);
        if (v > TIME_LIMIT && v != TIME_HOLD) begin
            return TIME_LIMIT;
        end
        return v;
    endfunction

    task automatic store_lamp_times(input logic [2:0] sel, input logic [15:0] on_t,
                                    input logic [15:0] off_t);
        logic [15:0] t;
        logic [15:0] r;
        if (int'(sel) < NUM_LAMPS) begin
            t = limit_dur(on_t);
            r = limit_dur(off_t);
            lamp_on_dur[sel]  = t;
            lamp_off_dur[sel] = r;
            if (is_timed_dur(t) && r == TIME_HOLD) begin
                lamp_on_cnt[sel] = '0;
            end
            if (t != TIME_HOLD && is_timed_dur(r)) begin
                lamp_off_cnt[sel] = '0;
            end
        end
    endtask

    task automatic advance_lamps(input logic [15:0] el, output logic [NUM_LAMPS-1:0] pat);
        logic [15:0] t;
        logic [15:0] r;
        for (int i = 0; i < NUM_LAMPS; i++) begin
            t = lamp_on_dur[i];
            r = lamp_off_dur[i];
            if (t == 16'd0) begin
                pat[i] = 1'b0;
            end else if (is_timed_dur(t) && is_timed_dur(r)) begin
                if (lamp_on_cnt[i] < {1'b0, t}) begin
                    lamp_on_cnt[i] = lamp_on_cnt[i] + {1'b0, el};
                    pat[i] = 1'b1;
                end else if (lamp_off_cnt[i] < {1'b0, r}) begin
                    lamp_off_cnt[i] = lamp_off_cnt[i] + {1'b0, el};
                    pat[i] = 1'b0;
                end else begin
                    // cycle restart reads as off
                    lamp_on_cnt[i]  = {1'b0, el};
                    lamp_off_cnt[i] = '0;
                    pat[i] = 1'b0;
                end
            end else if (is_timed_dur(t) && r == TIME_HOLD) begin
                if (lamp_on_cnt[i] < {1'b0, t}) begin
                    lamp_on_cnt[i] = lamp_on_cnt[i] + {1'b0, el};
                    pat[i] = 1'b1;
                end else begin
                    pat[i] = 1'b0;
                end
            end else if (t == TIME_HOLD && is_timed_dur(r)) begin
                if (lamp_off_cnt[i] < {1'b0, r}) begin
                    lamp_off_cnt[i] = lamp_off_cnt[i] + {1'b0, el};
                    pat[i] = 1'b0;
                end else begin
                    pat[i] = 1'b1;
                end
            end else begin
                pat[i] = 1'b1;
            end
        end
    endtask

    task automatic send_word(input t_stim_row row);
        logic [NUM_LAMPS-1:0] pat;
        t_drive_word          dw;
        start         <= 1'b1;
        i_opcode      <= row.op;
        i_lamp_select <= row.sel;
        i_on_time     <= row.on_t;
        i_off_time    <= row.off_t;
        i_elapsed     <= row.el;
        do begin
            @(posedge i_clk);
        end while (busy);
        if (row.op == OP_SET) begin
            store_lamp_times(row.sel, row.on_t, row.off_t);
            n_sets++;
        end else if (row.el != 16'd0) begin
            advance_lamps(row.el, pat);
            if (row.typed) begin
                pat = row.pat;
            end
            for (int i = 0; i < NUM_LAMPS; i++) begin
                dw.idx     = 3'(i);
                dw.lamp_on = pat[i];
                dw.last    = (i == NUM_LAMPS - 1);
                drive_q.push_back(dw);
            end
            n_ticks++;
        end
        @(negedge i_clk);
    endtask

    function automatic logic [15:0] pick_duration();
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return TIME_HOLD;
            2, 3:    return 16'($urandom_range(1, 400));
            4:       return 16'($urandom_range(59990, 65535));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_elapsed();
        case ($urandom_range(0, 9))
            0:       return 16'd0;
            1:       return 16'($urandom);
            2:       return 16'hFFFF;
            default: return 16'($urandom_range(1, 150));
        endcase
    endfunction

    always @(posedge i_clk) begin : drive_check
        t_drive_word want;
        if (i_rst_n && o_valid) begin
            n_results++;
            if (drive_q.size() == 0) begin
                report_mismatch($sformatf("unexpected drive word lamp %0d", o_lamp_index));
            end else begin
                want = drive_q.pop_front();
                if (o_lamp_index !== want.idx) begin
                    report_mismatch($sformatf("lamp_index %0d, want %0d",
                                              o_lamp_index, want.idx));
                end
                if (o_lamp_on !== want.lamp_on) begin
                    report_mismatch($sformatf("lamp %0d lamp_on %0b, want %0b",
                                              want.idx, o_lamp_on, want.lamp_on));
                end
                if (o_last !== want.last) begin
                    report_mismatch($sformatf("lamp %0d last %0b, want %0b",
                                              want.idx, o_last, want.last));
                end
            end
        end
    end

    initial begin : stimulus
        t_stim_row row;
        int        burst;
        int        gap;
        err_cnt   = 0;
        n_sets    = 0;
        n_ticks   = 0;
        n_results = 0;
        for (int i = 0; i < NUM_LAMPS; i++) begin
            lamp_on_dur[i]  = '0;
            lamp_off_dur[i] = '0;
            lamp_on_cnt[i]  = '0;
            lamp_off_cnt[i] = '0;
        end
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_opcode      = OP_TICK;
        i_lamp_select = '0;
        i_on_time     = '0;
        i_off_time    = '0;
        i_elapsed     = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int k = 0; k < DIR_N; k++) begin
            send_word(dir_tab[k]);
        end

        burst = 0;
        for (int k = 0; k < RAND_ITEMS; k++) begin
            if (burst == 0) begin
                // idle gap with noise on the payload
                start         <= 1'b0;
                i_opcode      <= 1'($urandom);
                i_lamp_select <= 3'($urandom);
                i_on_time     <= 16'($urandom);
                i_off_time    <= 16'($urandom);
                i_elapsed     <= 16'($urandom);
                gap = $urandom_range(1, 12);
                repeat (gap) @(negedge i_clk);
                burst = $urandom_range(1, 10);
            end
            burst--;
            row.op    = ($urandom_range(0, 99) < 35) ? OP_SET : OP_TICK;
            row.sel   = 3'($urandom);
            row.on_t  = pick_duration();
            row.off_t = pick_duration();
            row.el    = pick_elapsed();
            row.typed = 1'b0;
            row.pat   = '0;
            send_word(row);
        end
        start <= 1'b0;

        while (drive_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d set words and %0d ticks with nonzero elapsed time",
                 n_sets, n_ticks);
        $display("checked %0d drive words, %0d mismatches", n_results, err_cnt);
        if (err_cnt == 0) begin
            $display("tb_multi_lamp_blink_timer_top passed");
        end else begin
            $display("tb_multi_lamp_blink_timer_top failed");
        end
        $finish;
    end

endmodule

[files.f]
src/mlbt_pkg.sv
src/multi_lamp_blink_timer_top.sv
tb/sv/tb_multi_lamp_blink_timer_top.sv
